[hdl/bdq_pkg.sv]
// bdq_pkg: shared types and constants for the bounded deque with dump
// used by the channel interfaces and every module of the block but bdq_ram
package bdq_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_DUMP       = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DUMP_RD,
    S_DUMP_WR
  } state_e;

  // operands of the shared ring-position adder
  typedef struct packed {
    idx_t base;
    idx_t offset;
  } ring_req_t;

  // entry store access from the sequencer
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    logic  re;
    idx_t  raddr;
  } mem_req_t;

endpackage

[hdl/bdq_if.sv]
// bdq_in_if / bdq_out_if: valid/ready channels of the deque
// depends on bdq_pkg for field widths
interface bdq_in_if;
  logic                       valid;
  logic                       ready;
  logic [bdq_pkg::FUNC_W-1:0] func;
  bdq_pkg::data_t             value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface bdq_out_if;
  logic                         valid;
  logic                         ready;
  bdq_pkg::data_t               value_res;
  logic [bdq_pkg::STATUS_W-1:0] status;
  logic                         last;

  modport source (output valid, output value_res, output status, output last, input ready);
  modport sink   (input valid, input value_res, input status, input last, output ready);
endinterface

[hdl/bounded_deque_with_dump.sv]
// bounded_deque_with_dump: top level of the bounded double-ended queue
// depends on bdq_pkg, bdq_if, bdq_ring, bdq_ram and bdq_seq
//
// usage
//  - in_i carries one operation per transfer: func (push front, push back,
//    pop front, pop back, dump) and value, the word to push
//  - out_o carries results: value_res (stored word during a dump, else zero),
//    status (ok, empty, full with push dropped) and last on the final result
//  - push and pop give one result, in the cycle after the transfer, from an
//    output register; with the receiver ready, one push or pop per cycle
//  - a dump gives one result per stored word, front to back; each word goes
//    through the entry store read, then the output register, and the
//    sequencer waits for the read data before it issues the next read;
//    in_i is not ready until the last word is out
//  - a dump on an empty queue gives a single result with status empty
//  - unused func codes are taken and give no result
//  - reset empties the queue at once; the entry store is not cleared, only
//    occupied entries are ever read
//  - when the receiver stalls the result holds in the output register and
//    in_i drops ready until that result leaves
module bounded_deque_with_dump (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_in_if.sink    in_i,
  bdq_out_if.source out_o
);

  bdq_pkg::ring_req_t ring_req;
  bdq_pkg::idx_t      ring_pos;
  bdq_pkg::mem_req_t  mem_req;
  bdq_pkg::data_t     mem_rdata;

  // one adder serves push and pop index updates and the dump walk
  bdq_ring u_ring (
    .req_i (ring_req),
    .pos_o (ring_pos)
  );

  // ring store of the queue entries
  bdq_ram #(
    .Depth (bdq_pkg::DEPTH),
    .Width (bdq_pkg::DATA_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // operation decode, front index and count, dump walk, result register
  bdq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .ring_req_o  (ring_req),
    .ring_pos_i  (ring_pos),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

endmodule

[hdl/bdq_ram.sv]
// bdq_ram: generic one-write one-read memory with registered read data
// no dependencies
module bdq_ram #(
  parameter int Depth = 64,
  parameter int Width = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hdl/bdq_ring.sv]
// bdq_ring: shared ring-position adder, (base + offset) wrapped at DEPTH
// depends on bdq_pkg
module bdq_ring (
  input  bdq_pkg::ring_req_t req_i,
  output bdq_pkg::idx_t      pos_o
);

  logic [bdq_pkg::IDX_W:0] sum;

  always_comb begin
    sum = {1'b0, req_i.base} + {1'b0, req_i.offset};
    // both operands stay below DEPTH, so one subtract is enough
    if (sum >= (bdq_pkg::IDX_W + 1)'(bdq_pkg::DEPTH)) begin
      sum = sum - (bdq_pkg::IDX_W + 1)'(bdq_pkg::DEPTH);
    end
    pos_o = sum[bdq_pkg::IDX_W-1:0];
  end

endmodule

[hdl/bdq_seq.sv]
// bdq_seq: sequencer of the deque, holds front index, count and result register
// depends on bdq_pkg and the bdq_in_if / bdq_out_if interfaces
module bdq_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  bdq_in_if.sink              in_i,
  bdq_out_if.source           out_o,
  output bdq_pkg::ring_req_t  ring_req_o,
  input  bdq_pkg::idx_t       ring_pos_i,
  output bdq_pkg::mem_req_t   mem_req_o,
  input  bdq_pkg::data_t      mem_rdata_i
);

  bdq_pkg::state_e state_q, state_d;
  bdq_pkg::idx_t   front_q, front_d;
  bdq_pkg::cnt_t   count_q, count_d;
  bdq_pkg::idx_t   idx_q, idx_d;

  logic                         out_valid_q, out_valid_d;
  bdq_pkg::data_t               out_value_q, out_value_d;
  logic [bdq_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic                         out_last_q, out_last_d;

  logic out_free;
  logic take;
  logic is_full;
  logic is_empty;
  logic dump_last;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == bdq_pkg::S_IDLE) && out_free;
  assign take      = in_i.valid && in_i.ready;
  assign is_full   = (count_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign is_empty  = (count_q == '0);
  assign dump_last = ((bdq_pkg::CNT_W'(idx_q) + bdq_pkg::CNT_W'(1)) == count_q);

  assign out_o.valid     = out_valid_q;
  assign out_o.value_res = out_value_q;
  assign out_o.status    = out_status_q;
  assign out_o.last      = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdq_pkg::S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    count_d      = count_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    ring_req_o.base   = front_q;
    ring_req_o.offset = count_q[bdq_pkg::IDX_W-1:0];

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = ring_pos_i;
    mem_req_o.wdata = in_i.value;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = ring_pos_i;

    unique case (state_q)
      bdq_pkg::S_IDLE: begin
        unique case (in_i.func)
          bdq_pkg::FN_PUSH_FRONT: ring_req_o.offset = bdq_pkg::IDX_W'(bdq_pkg::DEPTH - 1);
          bdq_pkg::FN_POP_FRONT:  ring_req_o.offset = bdq_pkg::IDX_W'(1);
          default:                ring_req_o.offset = count_q[bdq_pkg::IDX_W-1:0];
        endcase

        if (take) begin
          unique case (in_i.func)
            bdq_pkg::FN_PUSH_FRONT, bdq_pkg::FN_PUSH_BACK: begin
              out_valid_d = 1'b1;
              out_value_d = '0;
              out_last_d  = 1'b1;
              if (is_full) begin
                out_status_d = bdq_pkg::ST_FULL;
              end else begin
                out_status_d = bdq_pkg::ST_OK;
                mem_req_o.we = 1'b1;
                count_d      = count_q + bdq_pkg::CNT_W'(1);
                if (in_i.func == bdq_pkg::FN_PUSH_FRONT) begin
                  front_d = ring_pos_i;
                end
              end
            end
            bdq_pkg::FN_POP_FRONT, bdq_pkg::FN_POP_BACK: begin
              out_valid_d = 1'b1;
              out_value_d = '0;
              out_last_d  = 1'b1;
              if (is_empty) begin
                out_status_d = bdq_pkg::ST_EMPTY;
              end else begin
                out_status_d = bdq_pkg::ST_OK;
                count_d      = count_q - bdq_pkg::CNT_W'(1);
                if (in_i.func == bdq_pkg::FN_POP_FRONT) begin
                  front_d = ring_pos_i;
                end
              end
            end
            bdq_pkg::FN_DUMP: begin
              if (is_empty) begin
                out_valid_d  = 1'b1;
                out_value_d  = '0;
                out_status_d = bdq_pkg::ST_EMPTY;
                out_last_d   = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = bdq_pkg::S_DUMP_RD;
              end
            end
            default: begin
              // unused codes are taken and dropped
            end
          endcase
        end
      end

      bdq_pkg::S_DUMP_RD: begin
        ring_req_o.offset = idx_q;
        mem_req_o.re      = 1'b1;
        state_d           = bdq_pkg::S_DUMP_WR;
      end

      bdq_pkg::S_DUMP_WR: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = mem_rdata_i;
          out_status_d = bdq_pkg::ST_OK;
          out_last_d   = dump_last;
          if (dump_last) begin
            state_d = bdq_pkg::S_IDLE;
          end else begin
            idx_d   = idx_q + bdq_pkg::IDX_W'(1);
            state_d = bdq_pkg::S_DUMP_RD;
          end
        end
      end

      default: begin
        state_d = bdq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[tb/bounded_deque_with_dump_test.sv]
// bounded_deque_with_dump_test: self-checking testbench of the bounded deque with dump
// depends on bdq_pkg, bdq_if and bounded_deque_with_dump; a local deque model predicts
// every result, and random stalls on both channels cover every phase of the block
`timescale 1ns / 100ps

module bounded_deque_with_dump_test;

  localparam int CLK_HALF      = 5;
  localparam int SETTLE_CYCLES = 16;   // quiet time after the last result
  localparam int MAX_REPORTS   = 10;
  localparam int FUNC_TOP      = (1 << bdq_pkg::FUNC_W) - 1;
  localparam int FUNC_UNUSED   = int'(bdq_pkg::FN_DUMP) + 1;   // first code the block ignores
  localparam int IDLE_LOW      = 7;
  localparam int IDLE_HIGH     = 85;

  // one expected transfer on the result channel
  typedef struct {
    bdq_pkg::data_t   value_res;
    bdq_pkg::status_e status;
    logic             last;
  } deque_result_t;

  logic clk_i;
  logic rst_ni;

  bdq_in_if  in_ch ();
  bdq_out_if out_ch ();

  bounded_deque_with_dump i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // local copy of the deque: ring of words, front position and fill level
  bdq_pkg::data_t deque_words [bdq_pkg::DEPTH];
  int             front_pos;
  int             word_count;

  deque_result_t expected_results [$];
  int            error_count;

  // idle percentages of the two sides, changed between phases
  int send_idle_pct;
  int recv_idle_pct;

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // hard stop in case the block hangs
  initial begin
    #10ms;
    $display("bounded_deque_with_dump: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // deque model: applies one operation and queues the results it causes
  // ---------------------------------------------------------------------------
  function automatic void add_result(bdq_pkg::data_t word, bdq_pkg::status_e st, logic fin);
    deque_result_t r;
    r.value_res = word;
    r.status    = st;
    r.last      = fin;
    expected_results.push_back(r);
  endfunction

  function automatic void apply_deque_op(logic [bdq_pkg::FUNC_W-1:0] op,
                                         bdq_pkg::data_t word);
    int i;
    case (op)
      bdq_pkg::FN_PUSH_FRONT: begin
        if (word_count == bdq_pkg::DEPTH) begin
          add_result('0, bdq_pkg::ST_FULL, 1'b1);   // full: word dropped
        end else begin
          front_pos = (front_pos + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH;
          deque_words[front_pos] = word;
          word_count++;
          add_result('0, bdq_pkg::ST_OK, 1'b1);
        end
      end
      bdq_pkg::FN_PUSH_BACK: begin
        if (word_count == bdq_pkg::DEPTH) begin
          add_result('0, bdq_pkg::ST_FULL, 1'b1);
        end else begin
          deque_words[(front_pos + word_count) % bdq_pkg::DEPTH] = word;
          word_count++;
          add_result('0, bdq_pkg::ST_OK, 1'b1);
        end
      end
      bdq_pkg::FN_POP_FRONT: begin
        if (word_count == 0) begin
          add_result('0, bdq_pkg::ST_EMPTY, 1'b1);
        end else begin
          front_pos = (front_pos + 1) % bdq_pkg::DEPTH;
          word_count--;
          add_result('0, bdq_pkg::ST_OK, 1'b1);
        end
      end
      bdq_pkg::FN_POP_BACK: begin
        if (word_count == 0) begin
          add_result('0, bdq_pkg::ST_EMPTY, 1'b1);
        end else begin
          word_count--;
          add_result('0, bdq_pkg::ST_OK, 1'b1);
        end
      end
      bdq_pkg::FN_DUMP: begin
        if (word_count == 0) begin
          add_result('0, bdq_pkg::ST_EMPTY, 1'b1);
        end else begin
          // front to back, last flag only on the final word
          for (i = 0; i < word_count; i++) begin
            add_result(deque_words[(front_pos + i) % bdq_pkg::DEPTH], bdq_pkg::ST_OK,
                       i == word_count - 1);
          end
        end
      end
      default: begin
        // unused codes are taken and give nothing
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // operation channel: one transfer per call, valid left high on return
  // ---------------------------------------------------------------------------
  task automatic send_op(logic [bdq_pkg::FUNC_W-1:0] op, bdq_pkg::data_t word);
    // random gaps before the transfer; valid drops only when a gap is taken
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= op;
    in_ch.value <= word;
    do @(posedge clk_i); while (!in_ch.ready);
    apply_deque_op(op, word);
  endtask

  // drop valid and hold off until every queued result has come back
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // random operation; percentages of pushes and pops, rest mostly dumps
  function automatic logic [bdq_pkg::FUNC_W-1:0] pick_op(int push_pct, int pop_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) begin
      return $urandom_range(1) ? bdq_pkg::FN_PUSH_BACK : bdq_pkg::FN_PUSH_FRONT;
    end else if (r < push_pct + pop_pct) begin
      return $urandom_range(1) ? bdq_pkg::FN_POP_BACK : bdq_pkg::FN_POP_FRONT;
    end else if (r < 97) begin
      return bdq_pkg::FN_DUMP;
    end else begin
      return bdq_pkg::FUNC_W'($urandom_range(FUNC_TOP, FUNC_UNUSED));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result channel: random ready, each transfer checked against the oldest
  // expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected result: value %0d status %0d last %0b",
                   out_ch.value_res, out_ch.status, out_ch.last);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_ch.value_res !== want.value_res || out_ch.status !== want.status ||
            out_ch.last !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display({"wrong result: expected value %0d status %0d last %0b, ",
                      "got value %0d status %0d last %0b"},
                     want.value_res, want.status, want.last,
                     out_ch.value_res, out_ch.status, out_ch.last);
          end
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // pops and dump with nothing stored, then the ignored codes
  task automatic test_empty_queue();
    int code;
    send_op(bdq_pkg::FN_POP_FRONT, bdq_pkg::data_t'($urandom));
    send_op(bdq_pkg::FN_POP_BACK, bdq_pkg::data_t'($urandom));
    send_op(bdq_pkg::FN_DUMP, bdq_pkg::data_t'($urandom));
    for (code = FUNC_UNUSED; code <= FUNC_TOP; code++) begin
      send_op(bdq_pkg::FUNC_W'(code), bdq_pkg::data_t'($urandom));
    end
  endtask

  // extreme words at both ends; a front push from position zero wraps the ring
  task automatic test_word_extremes();
    send_op(bdq_pkg::FN_PUSH_FRONT, bdq_pkg::data_t'(32'sh8000_0000));
    send_op(bdq_pkg::FN_PUSH_BACK, bdq_pkg::data_t'(32'sh7fff_ffff));
    send_op(bdq_pkg::FN_PUSH_FRONT, bdq_pkg::data_t'(-1));
    send_op(bdq_pkg::FN_PUSH_BACK, '0);
    send_op(bdq_pkg::FN_PUSH_FRONT, bdq_pkg::data_t'(32'sh5555_5555));
    send_op(bdq_pkg::FN_PUSH_BACK, bdq_pkg::data_t'(32'shaaaa_aaaa));
    send_op(bdq_pkg::FN_DUMP, '0);
    send_op(bdq_pkg::FN_POP_FRONT, '0);
    send_op(bdq_pkg::FN_POP_BACK, '0);
    send_op(bdq_pkg::FN_DUMP, '0);
    send_op(bdq_pkg::FN_POP_FRONT, '0);
    send_op(bdq_pkg::FN_POP_BACK, '0);
    send_op(bdq_pkg::FN_POP_BACK, '0);
    send_op(bdq_pkg::FN_POP_FRONT, '0);
    send_op(bdq_pkg::FN_DUMP, '0);
  endtask

  // push-heavy traffic until the deque is full, then dropped pushes and a full dump
  task automatic test_fill_to_full();
    int n;
    while (word_count < bdq_pkg::DEPTH) begin
      send_op(pick_op(88, 6), bdq_pkg::data_t'($urandom));
    end
    for (n = 0; n < 6; n++) begin
      send_op($urandom_range(1) ? bdq_pkg::FN_PUSH_BACK : bdq_pkg::FN_PUSH_FRONT,
              bdq_pkg::data_t'($urandom));
    end
    send_op(bdq_pkg::FN_DUMP, bdq_pkg::data_t'($urandom));
  endtask

  // pop-heavy traffic until the deque is empty, then pops and dump on empty
  task automatic test_drain_to_empty();
    while (word_count > 0) begin
      send_op(pick_op(6, 88), bdq_pkg::data_t'($urandom));
    end
    send_op(bdq_pkg::FN_POP_BACK, bdq_pkg::data_t'($urandom));
    send_op(bdq_pkg::FN_POP_FRONT, bdq_pkg::data_t'($urandom));
    send_op(bdq_pkg::FN_DUMP, bdq_pkg::data_t'($urandom));
  endtask

  // balanced traffic; halfway the sender holds off until all results are back
  task automatic test_random_mix();
    int n;
    for (n = 0; n < 110; n++) begin
      if (n == 55) begin
        wait_all_results();
      end
      send_op(pick_op(48, 38), bdq_pkg::data_t'($urandom));
    end
  endtask

  initial begin
    error_count   = 0;
    front_pos     = 0;
    word_count    = 0;
    send_idle_pct = IDLE_LOW;
    recv_idle_pct = IDLE_HIGH;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.func    = bdq_pkg::FN_PUSH_FRONT;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender rarely idles, receiver mostly stalls
    test_empty_queue();
    test_word_extremes();
    test_fill_to_full();
    wait_all_results();

    // swapped: slow sender, eager receiver
    send_idle_pct = IDLE_HIGH;
    recv_idle_pct = IDLE_LOW;
    test_drain_to_empty();
    wait_all_results();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix();
    wait_all_results();

    // anything arriving now is an extra result
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("bounded_deque_with_dump: match");
    end else begin
      $display("bounded_deque_with_dump: mismatch");
    end
    $finish;
  end

endmodule
